/* src/bvs_pkg.sv */
// bvs_pkg: shared types and constants for the bounded value set
// holds the item structs, command codes and the controller to datapath struct
// no dependencies
package bvs_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 5;

  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_REMOVE   = 2'd1;
  localparam logic [1:0] CMD_CONTAINS = 2'd2;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [VAL_W-1:0] value;
  } bvs_in_t;

  typedef struct packed {
    logic               success;
    logic               full_flag;
    logic [COUNT_W-1:0] element_count;
  } bvs_out_t;

  // per-cycle commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic look;
    logic apply;
  } bvs_ctrl_t;

endpackage

/* src/bvs_ctrl.sv */
// bvs_ctrl: sequencing state machine for the bounded value set
// walks each item through capture, slot compare and update; drives the result strobe
// depends on bvs_pkg
module bvs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output bvs_pkg::bvs_ctrl_t ctrl
);
  import bvs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_APPLY
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign ctrl.capture = start && (state_r == ST_IDLE);
  assign ctrl.look    = (state_r == ST_LOOK);
  assign ctrl.apply   = (state_r == ST_APPLY);

endmodule

/* src/bvs_dp.sv */
// bvs_dp: slot store, parallel compare and result register of the bounded value set
// acts on the capture, look and apply commands from bvs_ctrl
// depends on bvs_pkg
module bvs_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  bvs_pkg::bvs_ctrl_t ctrl,
  input  bvs_pkg::bvs_in_t  in_item,
  output bvs_pkg::bvs_out_t out_result
);
  import bvs_pkg::*;

  bvs_in_t              item_r;
  logic [VAL_W-1:0]     slot_r [CAPACITY];
  logic [CAPACITY-1:0]  valid_r, valid_nxt;
  logic [CNT_W-1:0]     occ_r, occ_nxt;
  logic [CAPACITY-1:0]  hit_r, free_r;
  logic [CAPACITY-1:0]  free_oh;
  logic                 hit_any, free_any, write_en;
  bvs_out_t             res_r, res_nxt;

  // lowest free slot as a one-hot mask
  assign free_oh  = free_r & (~free_r + CAPACITY'(1));
  assign hit_any  = |hit_r;
  assign free_any = |free_r;
  assign write_en = ctrl.apply && (item_r.command == CMD_ADD) && !hit_any && free_any;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      item_r <= in_item;
    end
  end

  // compare every slot against the held value
  always_ff @(posedge clk) begin
    if (ctrl.look) begin
      for (int i = 0; i < CAPACITY; i++) begin
        hit_r[i]  <= valid_r[i] && (slot_r[i] == item_r.value);
        free_r[i] <= !valid_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (write_en && free_oh[i]) begin
        slot_r[i] <= item_r.value;
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    res_nxt   = res_r;
    if (ctrl.apply) begin
      res_nxt.success   = 1'b0;
      res_nxt.full_flag = 1'b0;
      case (item_r.command)
        CMD_ADD: begin
          if (!hit_any) begin
            if (free_any) begin
              valid_nxt       = valid_r | free_oh;
              occ_nxt         = occ_r + CNT_W'(1);
              res_nxt.success = 1'b1;
            end else begin
              res_nxt.full_flag = 1'b1;
            end
          end
        end
        CMD_REMOVE: begin
          if (hit_any) begin
            valid_nxt = valid_r & ~hit_r;
            if (occ_r != '0) begin
              occ_nxt = occ_r - CNT_W'(1);
            end
            res_nxt.success = 1'b1;
          end
        end
        CMD_CONTAINS: begin
          res_nxt.success = hit_any;
        end
        default: begin
        end
      endcase
      res_nxt.element_count = COUNT_W'(occ_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_result = res_r;

endmodule

/* src/bounded_value_set.sv */
// bounded_value_set: top level of the set of up to CAPACITY distinct 32-bit values
// joins the bvs_ctrl state machine and the bvs_dp datapath
// depends on bvs_pkg, bvs_ctrl, bvs_dp
//
// An item (add, remove or contains on one value) is taken when start is high
// and busy is low. Each item is handled in turn: the value is captured, then
// all slots are compared against it in parallel and the lowest free slot is
// found, then the store and element count are updated. busy is high while
// the compare and the update run, so no new item is taken until the last one
// is through. The result is shown on out_result with out_valid high for
// exactly one cycle, in the cycle after the update; it cannot be held off,
// and a new item may be started in that same cycle. The slot valid bits are
// cleared by reset, so the block is ready as soon as reset is released.
module bounded_value_set (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bvs_pkg::bvs_in_t  in_item,
  output logic              out_valid,
  output bvs_pkg::bvs_out_t out_result
);
  import bvs_pkg::*;

  bvs_ctrl_t ctrl;

  bvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  bvs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_item    (in_item),
    .out_result (out_result)
  );

  // an add is either stored or refused for lack of room, never both
  a_no_success_and_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_result.success && out_result.full_flag))
    else $error("success and full_flag both set");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 busy ##1 (!busy && out_valid))
    else $error("item sequence broken");

  a_result_only_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe without item in progress");

endmodule

/* dv/tb_bounded_value_set.sv */
// tb_bounded_value_set: self-checking testbench for the bounded value set
// drives add, remove and contains items and checks every result against a local predictor
// depends on bvs_pkg and bounded_value_set
module tb_bounded_value_set;
  timeunit 1ns;
  timeprecision 1ps;

  import bvs_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         N_RANDOM    = 1720;
  localparam int         POOL_N      = 20;
  localparam int         STALL_LIMIT = 2000;
  localparam int         TAIL_CYCLES = 8;

  typedef struct {
    bvs_in_t item;
    int      idle_pct;
    bit      drain;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  bvs_in_t   in_item = '0;
  logic      out_valid;
  bvs_out_t  out_result;

  pending_t  pending_items[$];
  bvs_out_t  expected_results[$];

  // predictor state
  logic [VAL_W-1:0] held_value[CAPACITY];
  bit               held_valid[CAPACITY];
  int unsigned      held_count = 0;

  logic busy_s = 1'b1;
  bit   result_seen = 1'b0;
  int   n_errors = 0;
  int   stall_cycles = 0;

  bounded_value_set uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bvs_out_t predict_result(bvs_in_t it);
    bvs_out_t r;
    int hit;
    int free_idx;
    r = '0;
    hit = -1;
    free_idx = -1;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (held_valid[i] && held_value[i] == it.value) hit = i;
      if (!held_valid[i]) free_idx = i;
    end
    case (it.command)
      CMD_ADD: begin
        if (hit < 0) begin
          if (free_idx < 0) begin
            r.full_flag = 1'b1;
          end else begin
            held_value[free_idx] = it.value;
            held_valid[free_idx] = 1'b1;
            held_count++;
            r.success = 1'b1;
          end
        end
      end
      CMD_REMOVE: begin
        if (hit >= 0) begin
          held_valid[hit] = 1'b0;
          if (held_count > 0) held_count--;
          r.success = 1'b1;
        end
      end
      CMD_CONTAINS: begin
        r.success = (hit >= 0);
      end
      default: ;
    endcase
    r.element_count = held_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $time, what);
    n_errors++;
  endtask

  task automatic queue_item(logic [1:0] cmd, logic [VAL_W-1:0] val, int pct, bit drain);
    pending_t p;
    p.item.command = cmd;
    p.item.value   = val;
    p.idle_pct     = pct;
    p.drain        = drain;
    pending_items.push_back(p);
  endtask

  // driver: an item is taken at an edge with start high and busy low
  always @(posedge clk) begin
    pending_t nxt;
    if (start && !busy_s) begin
      expected_results.push_back(predict_result(in_item));
    end
    if (!start || !busy_s) begin
      if (rst_n && pending_items.size() != 0 &&
          (!pending_items[0].drain || expected_results.size() == 0) &&
          $urandom_range(99) >= pending_items[0].idle_pct) begin
        nxt = pending_items.pop_front();
        start   <= 1'b1;
        in_item <= nxt.item;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: sample mid-cycle, away from the edge where the block updates
  always @(negedge clk) begin
    bvs_out_t exp_r;
    busy_s      = busy;
    result_seen = 1'b0;
    if (rst_n && out_valid !== 1'b0) begin
      result_seen = 1'b1;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        exp_r = expected_results.pop_front();
        if (out_result.success !== exp_r.success)
          report_mismatch($sformatf("success %b, expected %b",
                                    out_result.success, exp_r.success));
        if (out_result.full_flag !== exp_r.full_flag)
          report_mismatch($sformatf("full_flag %b, expected %b",
                                    out_result.full_flag, exp_r.full_flag));
        if (out_result.element_count !== exp_r.element_count)
          report_mismatch($sformatf("element_count %0d, expected %0d",
                                    out_result.element_count, exp_r.element_count));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy_s) || result_seen) stall_cycles = 0;
    else stall_cycles = stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("bounded_value_set: mismatch");
      $finish;
    end
  end

  initial begin
    logic [VAL_W-1:0] pool[POOL_N];
    logic [VAL_W-1:0] val;
    logic [1:0]       cmd;
    int               add_bias;
    int               pct;
    int               r;

    // directed part: extremes, duplicates, filling up, refusal when full
    queue_item(CMD_CONTAINS, 32'h0000_0000, 29, 1'b0);
    queue_item(CMD_REMOVE,   32'h0000_0005, 29, 1'b0);
    queue_item(CMD_ADD,      32'h8000_0000, 29, 1'b0);
    queue_item(CMD_ADD,      32'h7FFF_FFFF, 29, 1'b0);
    queue_item(CMD_ADD,      32'hFFFF_FFFF, 29, 1'b0);
    queue_item(CMD_ADD,      32'h0000_0000, 29, 1'b0);
    queue_item(CMD_ADD,      32'h0000_0000, 29, 1'b0);
    queue_item(CMD_CONTAINS, 32'h7FFF_FFFF, 29, 1'b0);
    queue_item(CMD_CONTAINS, 32'h7FFF_FFFE, 29, 1'b0);
    queue_item(CMD_UNUSED,   32'hFFFF_FFFF, 29, 1'b0);
    for (int i = 1; i <= CAPACITY - 4; i++) queue_item(CMD_ADD, i, 29, 1'b0);
    queue_item(CMD_ADD,      32'd100, 29, 1'b0);
    queue_item(CMD_ADD,      32'd1, 29, 1'b0);
    queue_item(CMD_REMOVE,   32'h8000_0000, 29, 1'b0);
    queue_item(CMD_ADD,      32'd100, 29, 1'b0);
    queue_item(CMD_CONTAINS, 32'd100, 29, 1'b0);
    queue_item(CMD_REMOVE,   32'd100, 29, 1'b0);

    // random part drawn mostly from a small pool so that hits and full are common
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_N; i++) pool[i] = $urandom;
    add_bias = 60;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 64 == 0) add_bias = $urandom_range(1) ? 60 : 20;
      if ($urandom_range(99) < 5) pool[$urandom_range(POOL_N - 1)] = $urandom;
      val = ($urandom_range(99) < 85) ? pool[$urandom_range(POOL_N - 1)] : $urandom;
      r = $urandom_range(99);
      if (r < 4) cmd = CMD_UNUSED;
      else if (r < 4 + add_bias) cmd = CMD_ADD;
      else if (r < 4 + add_bias + (96 - add_bias) / 2) cmd = CMD_REMOVE;
      else cmd = CMD_CONTAINS;
      if (n < N_RANDOM / 3) pct = 29;
      else if (n < 2 * N_RANDOM / 3) pct = 60;
      else pct = 0;
      // hold off at each phase change until the block has drained
      queue_item(cmd, val, pct, n == 0 || n == N_RANDOM / 3 || n == 2 * N_RANDOM / 3);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_items.size() != 0 || start || expected_results.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (n_errors == 0) begin
      $display("bounded_value_set: match");
    end else begin
      $display("bounded_value_set: mismatch");
    end
    $finish;
  end

endmodule

/* bounded_value_set.f */
src/bvs_pkg.sv
src/bvs_ctrl.sv
src/bvs_dp.sv
src/bounded_value_set.sv
dv/tb_bounded_value_set.sv
